### rtl/core/ast_pkg.sv
// Shared types, codes and character helpers for the assembly source tokenizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ast_pkg;

    // Depth of the token-bundle queue between front and back (power of two)
    localparam int Q_DEPTH = 4;

    // Token slots per source byte: closed token, punct/error/final open token, end
    localparam int N_SLOTS = 3;

    // Width of the packed word prefix (first seven bytes)
    localparam int WORD_BITS = 56;
    localparam int WORD_KEEP = 7;

    // Scanner modes
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WORD = 3'b010,
        S_NUM  = 3'b100
    } t_mode;

    // Raw class of a token as seen by the scanner
    typedef enum logic [2:0] {
        CLS_WORD  = 3'd0,
        CLS_NUM   = 3'd1,
        CLS_COLON = 3'd2,
        CLS_COMMA = 3'd3,
        CLS_ERROR = 3'd4,
        CLS_END   = 3'd5
    } t_cls;

    // Token kinds on the result port
    typedef enum logic [3:0] {
        K_SECTION = 4'd0,
        K_MOV     = 4'd1,
        K_HLT     = 4'd2,
        K_REG     = 4'd3,
        K_IDENT   = 4'd4,
        K_IMM     = 4'd5,
        K_COLON   = 4'd6,
        K_COMMA   = 4'd7,
        K_END     = 4'd8,
        K_ERROR   = 4'd9
    } t_kind;

    // Width-independent part of one token slot
    typedef struct packed {
        logic                 vld;
        t_cls                 cls;
        logic                 word_long;
        logic [WORD_BITS-1:0] chars;
    } t_tok_info;

    // Special characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Keywords, packed right-aligned one byte per character
    localparam logic [WORD_BITS-1:0] W_SECTION = 56'h73_65_63_74_69_6F_6E;
    localparam logic [WORD_BITS-1:0] W_TEXT    = 56'h2E_74_65_78_74;
    localparam logic [WORD_BITS-1:0] W_DATA    = 56'h2E_64_61_74_61;
    localparam logic [WORD_BITS-1:0] W_MOV     = 56'h6D_6F_76;
    localparam logic [WORD_BITS-1:0] W_HLT     = 56'h68_6C_74;

    // 64-bit register names in encoding order
    localparam logic [WORD_BITS-1:0] REG_NAME [16] = '{
        56'h72_61_78, 56'h72_63_78, 56'h72_64_78, 56'h72_62_78,
        56'h72_73_70, 56'h72_62_70, 56'h72_73_69, 56'h72_64_69,
        56'h72_38,    56'h72_39,    56'h72_31_30, 56'h72_31_31,
        56'h72_31_32, 56'h72_31_33, 56'h72_31_34, 56'h72_31_35
    };
    localparam logic [2:0] REG_LEN [16] = '{
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

`default_nettype wire

### rtl/core/ast_front.sv
// Front end: accepts source bytes, tracks the open token and emits a bundle
// of up to three token slots per token-yielding byte. Depends on ast_pkg.
`default_nettype none

module ast_front #(
    parameter int POSITION_BITS = 16,
    parameter int LW            = 8,
    parameter int LENGTH_MAX    = 255
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic                         i_full,
    input  wire logic [7:0]                   i_ch,
    input  wire logic                         i_eos,
    output logic                              o_qpush,
    output ast_pkg::t_tok_info [2:0]          o_info,
    output logic [2:0][POSITION_BITS-1:0]     o_start,
    output logic [2:0][LW-1:0]                o_len
);
    import ast_pkg::*;

    localparam logic [LW-1:0] LEN_SAT  = LW'(LENGTH_MAX);
    localparam logic [LW-1:0] LEN_KEEP = LW'(WORD_KEEP);
    localparam logic [LW-1:0] LEN_ONE  = LW'(1);

    t_mode                    r_mode,   n_mode;
    logic [POSITION_BITS-1:0] r_pos,    n_pos;
    logic [POSITION_BITS-1:0] r_start,  n_start;
    logic [LW-1:0]            r_len,    n_len;
    logic [WORD_BITS-1:0]     r_chars,  n_chars;
    logic                     r_long,   n_long;
    logic                     r_halted, n_halted;

    logic accept;
    logic alpha, digit, space, word_lead, word_ch, alnum;
    logic do_ext, close;

    assign accept = i_push && !i_full;

    // character classes
    assign alpha     = is_alpha(i_ch);
    assign digit     = is_digit(i_ch);
    assign space     = is_space(i_ch);
    assign alnum     = alpha || digit;
    assign word_lead = alpha || i_ch == CH_UNDER || i_ch == CH_DOT;
    assign word_ch   = word_lead || digit;

    assign do_ext = (r_mode == S_WORD && word_ch) || (r_mode == S_NUM && alnum);
    assign close  = (r_mode != S_IDLE) && !do_ext;

    // next state and the slots this byte produces
    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_start  = r_start;
        n_len    = r_len;
        n_chars  = r_chars;
        n_long   = r_long;
        n_halted = r_halted;
        o_info   = '0;
        o_start  = '0;
        o_len    = '0;

        if (!r_halted) begin
            // slot 0: open token ended by this byte
            if (close) begin
                o_info[0].vld       = 1'b1;
                o_info[0].cls       = (r_mode == S_NUM) ? CLS_NUM : CLS_WORD;
                o_info[0].word_long = r_long;
                o_info[0].chars     = r_chars;
                o_start[0]          = r_start;
                o_len[0]            = r_len;
                n_mode              = S_IDLE;
            end

            if (do_ext) begin
                if (r_mode == S_WORD) begin
                    if (r_len < LEN_KEEP && !r_long) begin
                        n_chars = {r_chars[WORD_BITS-9:0], i_ch};
                    end else begin
                        n_long = 1'b1;
                    end
                end
                if (r_len < LEN_SAT) begin
                    n_len = r_len + LEN_ONE;
                end
            end else if (space) begin
                // skipped
            end else if (word_lead || digit) begin
                n_mode  = word_lead ? S_WORD : S_NUM;
                n_start = r_pos;
                n_len   = LEN_ONE;
                n_chars = {{(WORD_BITS-8){1'b0}}, i_ch};
                n_long  = 1'b0;
            end else begin
                // slot 1: colon, comma or error
                o_info[1].vld = 1'b1;
                o_start[1]    = r_pos;
                o_len[1]      = LEN_ONE;
                if (i_ch == CH_COLON) begin
                    o_info[1].cls = CLS_COLON;
                end else if (i_ch == CH_COMMA) begin
                    o_info[1].cls = CLS_COMMA;
                end else begin
                    o_info[1].cls = CLS_ERROR;
                    n_halted      = 1'b1;
                end
            end

            n_pos = r_pos + 1'b1;

            // end of source: flush the open token, then the end marker
            if (i_eos && !n_halted) begin
                if (n_mode != S_IDLE) begin
                    o_info[1].vld       = 1'b1;
                    o_info[1].cls       = (n_mode == S_NUM) ? CLS_NUM : CLS_WORD;
                    o_info[1].word_long = n_long;
                    o_info[1].chars     = n_chars;
                    o_start[1]          = n_start;
                    o_len[1]            = n_len;
                end
                o_info[2].vld = 1'b1;
                o_info[2].cls = CLS_END;
                o_start[2]    = n_pos;
                n_mode        = S_IDLE;
                n_pos         = '0;
                n_start       = '0;
                n_len         = '0;
                n_chars       = '0;
                n_long        = 1'b0;
            end
        end
    end

    assign o_qpush = accept && (o_info[0].vld || o_info[1].vld || o_info[2].vld);

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= S_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_chars  <= '0;
            r_long   <= 1'b0;
            r_halted <= 1'b0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_len    <= n_len;
            r_chars  <= n_chars;
            r_long   <= n_long;
            r_halted <= n_halted;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ast_queue.sv
// Short FIFO of token bundles between front and back.
// Depends on ast_pkg for its depth.
`default_nettype none

module ast_queue #(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_rdata,
    output logic              o_empty
);
    import ast_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic [W-1:0]  r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = r_count == CW'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/ast_classify.sv
// Keyword and register-name match of one token slot, plus kind mapping.
// Depends on ast_pkg for the name tables.
`default_nettype none

module ast_classify #(
    parameter int LW = 8
) (
    input  ast_pkg::t_tok_info i_info,
    input  wire logic [LW-1:0] i_len,
    output ast_pkg::t_kind     o_kind,
    output logic [3:0]         o_reg_index
);
    import ast_pkg::*;

    function automatic logic word_is(input t_tok_info info, input logic [LW-1:0] len,
                                     input logic [WORD_BITS-1:0] pat, input logic [2:0] n);
        return !info.word_long && len == LW'(n) && info.chars == pat;
    endfunction

    logic       is_sect, is_mov, is_hlt, is_reg;
    logic [3:0] reg_idx;

    // parallel compares against the keyword and register tables
    always_comb begin
        is_sect = word_is(i_info, i_len, W_SECTION, 3'd7)
               || word_is(i_info, i_len, W_TEXT, 3'd5)
               || word_is(i_info, i_len, W_DATA, 3'd5);
        is_mov  = word_is(i_info, i_len, W_MOV, 3'd3);
        is_hlt  = word_is(i_info, i_len, W_HLT, 3'd3);
        is_reg  = 1'b0;
        reg_idx = '0;
        for (int i = 0; i < 16; i++) begin
            if (!is_reg && word_is(i_info, i_len, REG_NAME[i], REG_LEN[i])) begin
                is_reg  = 1'b1;
                reg_idx = 4'(i);
            end
        end
    end

    // kind of the slot
    always_comb begin
        o_reg_index = '0;
        case (i_info.cls)
            CLS_WORD: begin
                if (is_sect) begin
                    o_kind = K_SECTION;
                end else if (is_mov) begin
                    o_kind = K_MOV;
                end else if (is_hlt) begin
                    o_kind = K_HLT;
                end else if (is_reg) begin
                    o_kind      = K_REG;
                    o_reg_index = reg_idx;
                end else begin
                    o_kind = K_IDENT;
                end
            end
            CLS_NUM:   o_kind = K_IMM;
            CLS_COLON: o_kind = K_COLON;
            CLS_COMMA: o_kind = K_COMMA;
            CLS_END:   o_kind = K_END;
            default:   o_kind = K_ERROR;
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/ast_back.sv
// Back end: walks the slots of the head bundle, classifies each token and
// holds it in the result register. Depends on ast_pkg and ast_classify.
`default_nettype none

module ast_back #(
    parameter int POSITION_BITS = 16,
    parameter int LW            = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_qempty,
    input  ast_pkg::t_tok_info [2:0]           i_info,
    input  wire logic [2:0][POSITION_BITS-1:0] i_start,
    input  wire logic [2:0][LW-1:0]            i_len,
    output logic                               o_qpop,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output logic [3:0]                         o_kind,
    output logic [15:0]                        o_start_res,
    output logic [7:0]                         o_length,
    output logic [3:0]                         o_reg_index,
    output logic                               o_last_of_run
);
    import ast_pkg::*;

    logic [2:0]     r_done;
    logic           r_ovalid;
    logic [3:0]     r_kind;
    logic [15:0]    r_start;
    logic [7:0]     r_len;
    logic [3:0]     r_reg;
    logic           r_last;

    logic [2:0]     rem, sel_oh;
    logic [1:0]     sel;
    logic           more, load;
    t_tok_info      sel_info;
    logic [LW-1:0]  sel_len;
    logic [31:0]    start_ext;
    logic [15:0]    len_ext;
    t_kind          kind;
    logic [3:0]     reg_idx;

    // pick the oldest slot of the head bundle not yet sent
    assign rem = {i_info[2].vld, i_info[1].vld, i_info[0].vld} & ~r_done;

    always_comb begin
        if (rem[0]) begin
            sel = 2'd0;
        end else if (rem[1]) begin
            sel = 2'd1;
        end else begin
            sel = 2'd2;
        end
    end

    assign sel_oh    = 3'b001 << sel;
    assign more      = |(rem & ~sel_oh);
    assign load      = !i_qempty && (!r_ovalid || i_pop);
    assign o_qpop    = load && !more;
    assign sel_info  = i_info[sel];
    assign sel_len   = i_len[sel];
    assign start_ext = 32'(i_start[sel]);
    assign len_ext   = 16'(sel_len);

    ast_classify #(
        .LW (LW)
    ) u_classify (
        .i_info      (sel_info),
        .i_len       (sel_len),
        .o_kind      (kind),
        .o_reg_index (reg_idx)
    );

    // slot progress within the head bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_done   <= more ? (r_done | sel_oh) : 3'b000;
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= kind;
            r_start <= start_ext[15:0];
            r_len   <= len_ext[7:0];
            r_reg   <= reg_idx;
            r_last  <= !more;
        end
    end

    assign o_empty       = !r_ovalid;
    assign o_kind        = r_kind;
    assign o_start_res   = r_start;
    assign o_length      = r_len;
    assign o_reg_index   = r_reg;
    assign o_last_of_run = r_last;

endmodule

`default_nettype wire

### rtl/core/assembly_source_tokenizer_top.sv
// Top level of the assembly source tokenizer: scanner front, bundle queue,
// classifying back end. Depends on ast_pkg, ast_front, ast_queue, ast_back.
//
//   Channel | Handshake        | Beat
//   --------+------------------+-----------------------------------------------
//   in      | push / full      | i_ch, i_end_of_source
//   out     | pop / empty      | o_kind, o_start_res, o_length, o_reg_index,
//           |                  | o_last_of_run
//
// A source byte is taken every cycle while the bundle queue has room; its
// tokens are formed in that same cycle. The back end sends one token a cycle
// while the result is popped, so a byte with two or three tokens holds the
// result side while the 4-entry queue keeps the input open. Tokens pass the
// queue and the result register. Synchronous active-low reset clears scanner
// state, queue and output valid; an error token halts scanning until reset.
`default_nettype none

module assembly_source_tokenizer_top #(
    parameter int POSITION_BITS = 16,
    parameter int LENGTH_MAX    = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_end_of_source,
    input  wire logic        pop,
    output logic             empty,
    output logic [3:0]       o_kind,
    output logic [15:0]      o_start_res,
    output logic [7:0]       o_length,
    output logic [3:0]       o_reg_index,
    output logic             o_last_of_run
);
    import ast_pkg::*;

    localparam int LW = $clog2(LENGTH_MAX + 1);
    localparam int QW = N_SLOTS * ($bits(t_tok_info) + POSITION_BITS + LW);

    logic                          f_push;
    t_tok_info [2:0]               f_info;
    logic [2:0][POSITION_BITS-1:0] f_start;
    logic [2:0][LW-1:0]            f_len;

    logic                          q_full, q_empty, q_pop;
    logic [QW-1:0]                 q_rdata;
    t_tok_info [2:0]               b_info;
    logic [2:0][POSITION_BITS-1:0] b_start;
    logic [2:0][LW-1:0]            b_len;

    assign full = q_full;

    ast_front #(
        .POSITION_BITS (POSITION_BITS),
        .LW            (LW),
        .LENGTH_MAX    (LENGTH_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_full  (q_full),
        .i_ch    (i_ch),
        .i_eos   (i_end_of_source),
        .o_qpush (f_push),
        .o_info  (f_info),
        .o_start (f_start),
        .o_len   (f_len)
    );

    ast_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata ({f_info, f_start, f_len}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign {b_info, b_start, b_len} = q_rdata;

    ast_back #(
        .POSITION_BITS (POSITION_BITS),
        .LW            (LW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qempty      (q_empty),
        .i_info        (b_info),
        .i_start       (b_start),
        .i_len         (b_len),
        .o_qpop        (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_kind        (o_kind),
        .o_start_res   (o_start_res),
        .o_length      (o_length),
        .o_reg_index   (o_reg_index),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire
